### hw/rtl/sfc_pkg.sv
// Shared constants and CRC-16/MODBUS byte update for the scope frame encoder.
// No dependencies; used by every module of the block.
package sfc_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int MAX_CHANNELS  = 4;

  // Channel count clamped to 1..MAX_CHANNELS
  localparam int ACTIVE_CH =
    (CHANNEL_COUNT < 1) ? 1 : ((CHANNEL_COUNT > MAX_CHANNELS) ? MAX_CHANNELS : CHANNEL_COUNT);

  localparam int NUM_DATA_BYTES = 2 * ACTIVE_CH;
  localparam int FRAME_LEN      = NUM_DATA_BYTES + 2;
  localparam int CNT_W          = $clog2(FRAME_LEN);

  localparam int CH_W      = 16;
  localparam int IN_DATA_W = CH_W * MAX_CHANNELS;

  localparam logic [CNT_W-1:0] CNT_DATA_END = CNT_W'(NUM_DATA_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(FRAME_LEN - 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;

  // One byte of reflected CRC-16, eight bit steps
  function automatic crc_t crc_byte(input crc_t crc_in, input byte_t b);
    crc_t c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/scope_frame_crc16_encoder_top.sv
// Scope frame encoder top: byte chain, CRC cell, frame sequencer, output register.
// Depends on sfc_pkg, sfc_byte_cell, sfc_crc_cell.

// Each accepted sample set becomes one frame of ten bytes on the output stream:
// channel 0..3, each low byte then high byte, then the CRC-16/MODBUS of those
// eight bytes, low byte first, with tlast on the final CRC byte. One byte leaves
// per cycle unless out_tready stalls, so the output byte rate sets throughput;
// the next sample set is taken in the cycle the previous frame's last byte
// moves into the output register, so frames run back to back with no gap.
// Accepted samples load the byte cells, then byte 0 enters the output register.
module scope_frame_crc16_encoder_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // channel_0 [15:0], channel_1 [31:16],
                                  // channel_2 [47:32], channel_3 [63:48]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // frame_byte [7:0]
  output logic        out_tlast   // last_byte
);

  localparam int NB = sfc_pkg::NUM_DATA_BYTES;

  logic                      busy_r, busy_nxt;
  logic [sfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  sfc_pkg::byte_t            out_data_r, out_data_nxt;
  logic                      out_last_r, out_last_nxt;

  logic           adv;
  logic           emit;
  logic           in_acc;
  logic           in_data_phase;
  logic           at_last;
  sfc_pkg::byte_t cell_q [NB];
  sfc_pkg::crc_t  crc;
  sfc_pkg::byte_t emit_byte;

  assign adv           = !out_valid_r || out_tready;
  assign emit          = adv && busy_r;
  assign at_last       = (cnt_r == sfc_pkg::CNT_LAST);
  assign in_data_phase = (cnt_r < sfc_pkg::CNT_DATA_END);
  assign in_tready     = !busy_r || (emit && at_last);
  assign in_acc        = in_tvalid && in_tready;

  // Byte chain; cell 0 is the head feeding the CRC cell and the output
  for (genvar i = 0; i < NB; i++) begin : g_cell
    sfc_pkg::byte_t next_b;
    if (i == NB - 1) begin : g_tail
      assign next_b = 8'h00;
    end else begin : g_mid
      assign next_b = cell_q[i+1];
    end
    sfc_byte_cell u_cell (
      .clk       (clk),
      .load      (in_acc),
      .shift     (emit && in_data_phase),
      .load_byte (in_tdata[8*i +: 8]),
      .next_byte (next_b),
      .byte_q    (cell_q[i])
    );
  end

  sfc_crc_cell u_crc (
    .clk     (clk),
    .init    (in_acc),
    .update  (emit && in_data_phase),
    .data_in (cell_q[0]),
    .crc_q   (crc)
  );

  always_comb begin
    if (in_data_phase) begin
      emit_byte = cell_q[0];
    end else if (cnt_r == sfc_pkg::CNT_DATA_END) begin
      emit_byte = crc[7:0];
    end else begin
      emit_byte = crc[15:8];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      out_data_nxt  = emit_byte;
      out_last_nxt  = at_last;
    end
    if (emit) begin
      if (at_last) begin
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sfc_pkg::CNT_LAST)
    else $error("frame counter past last byte");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0)
    else $error("counter not parked while idle");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r && cnt_r == '0)
    else $error("accepted item did not start a frame");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    emit && at_last && !in_acc |=> !busy_r && out_tvalid && out_tlast)
    else $error("frame end not marked or sequencer still busy");

  a_no_early_accept: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !at_last |-> !in_tready)
    else $error("input taken mid-frame");
`endif

endmodule

### hw/rtl/sfc_byte_cell.sv
// One byte cell of the frame shift chain: parallel load, shift from neighbor.
// Depends on sfc_pkg.
module sfc_byte_cell (
  input  logic          clk,
  input  logic          load,
  input  logic          shift,
  input  sfc_pkg::byte_t load_byte,
  input  sfc_pkg::byte_t next_byte,
  output sfc_pkg::byte_t byte_q
);

  sfc_pkg::byte_t byte_r;
  sfc_pkg::byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (load) begin
      byte_nxt = load_byte;
    end else if (shift) begin
      byte_nxt = next_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

### hw/rtl/sfc_crc_cell.sv
// CRC cell at the head of the byte chain: folds in one data byte per cycle while update is high.
// Depends on sfc_pkg.
module sfc_crc_cell (
  input  logic           clk,
  input  logic           init,
  input  logic           update,
  input  sfc_pkg::byte_t data_in,
  output sfc_pkg::crc_t  crc_q
);

  sfc_pkg::crc_t crc_r;
  sfc_pkg::crc_t crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (init) begin
      crc_nxt = sfc_pkg::CRC_INIT;
    end else if (update) begin
      crc_nxt = sfc_pkg::crc_byte(crc_r, data_in);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc_q = crc_r;

endmodule
